@@ hw/rtl/ps2mt_pkg.sv @@
// Package for the PS/2 mouse packet tracker: types, codes and constants.
package ps2mt_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned CfgDw  = 32;
  localparam int unsigned CfgAw  = 3;

  localparam logic [SizeW-1:0] WidthRst  = 13'd800;
  localparam logic [SizeW-1:0] HeightRst = 13'd600;
  localparam logic [PosW-1:0]  CurXRst   = 12'd400;
  localparam logic [PosW-1:0]  CurYRst   = 12'd300;
  localparam logic [PosW-1:0]  PosMax    = 12'd4095;

  // header byte bit positions
  localparam int unsigned HdrBtnLeft  = 0;
  localparam int unsigned HdrBtnRight = 1;
  localparam int unsigned HdrSync     = 3;
  localparam int unsigned HdrSignX    = 4;
  localparam int unsigned HdrSignY    = 5;
  localparam int unsigned HdrOvfX     = 6;
  localparam int unsigned HdrOvfY     = 7;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_ABSORB  = 2'd0,
    ST_APPLY   = 2'd1,
    ST_DROP    = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // clamp limit: zero behaves like one, saturate at PosMax
  function automatic logic [PosW-1:0] clamp_limit(input logic [SizeW-1:0] size);
    logic [PosW-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else if (size[SizeW-1]) begin
      lim = PosMax;
    end else begin
      lim = size[PosW-1:0] - PosW'(1);
    end
    return lim;
  endfunction

  // clamp a signed 14-bit position into [0, lim]
  function automatic logic [PosW-1:0] clamp_pos(input logic signed [PosW+1:0] v,
                                                input logic [PosW-1:0] lim);
    logic [PosW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker: byte stream in, cursor and button state out.
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   in_tdata[7:0] rx_byte
//  out_     out  out_tvalid/out_tready out_tuser status, out_tdata position and buttons
//  cfg_     in   APB psel/penable      reg 0 screen_width, reg 4 screen_height
//
// One item per cycle unless out_tready stalls; each accepted byte yields one result item in the next cycle.
// Decode, add and clamp run in the accept cycle into the output register.
// in_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) restores cursor 400,300 and screen 800x600.
module ps2_mouse_packet_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] pos_x, [23:12] pos_y, [26:24] button_bits,
                                  // [27] left_press, [28] right_press, [31:29] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [ps2mt_pkg::CfgAw-1:0] cfg_paddr,
  input  logic [ps2mt_pkg::CfgDw-1:0] cfg_pwdata,
  output logic [ps2mt_pkg::CfgDw-1:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned PosW  = ps2mt_pkg::PosW;
  localparam int unsigned SizeW = ps2mt_pkg::SizeW;
  localparam int unsigned BtnW  = ps2mt_pkg::BtnW;

  // configuration
  logic [SizeW-1:0] width_r, height_r;
  logic             cfg_wr;
  ps2mt_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = ps2mt_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ps2mt_pkg::WidthRst;
      height_r <= ps2mt_pkg::HeightRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ps2mt_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[SizeW-1:0];
        ps2mt_pkg::REG_HEIGHT: height_r <= cfg_pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ps2mt_pkg::REG_WIDTH:  cfg_prdata = {{(ps2mt_pkg::CfgDw-SizeW){1'b0}}, width_r};
      ps2mt_pkg::REG_HEIGHT: cfg_prdata = {{(ps2mt_pkg::CfgDw-SizeW){1'b0}}, height_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // tracker state
  ps2mt_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        hdr_r, hdr_nxt;
  logic [7:0]        dx_r, dx_nxt;
  logic [PosW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [BtnW-1:0]   btn_r, btn_nxt;
  logic              ledge_r, ledge_nxt, redge_r, redge_nxt;
  ps2mt_pkg::status_t status_nxt;

  // output register
  logic               out_valid_r;
  ps2mt_pkg::status_t out_status_r;
  logic [PosW-1:0]    out_x_r, out_y_r;
  logic [BtnW-1:0]    out_btn_r;
  logic               out_lp_r, out_rp_r;

  logic in_acc;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;

  logic signed [PosW+1:0] dx_s, dy_s, sum_x, sum_y;

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    dx_nxt     = dx_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    btn_nxt    = btn_r;
    ledge_nxt  = ledge_r;
    redge_nxt  = redge_r;
    status_nxt = ps2mt_pkg::ST_ABSORB;

    // 9-bit signed deltas, sign-extended to the sum width
    dx_s  = $signed({{(PosW-6){hdr_r[ps2mt_pkg::HdrSignX]}}, dx_r});
    dy_s  = $signed({{(PosW-6){hdr_r[ps2mt_pkg::HdrSignY]}}, in_tdata});
    sum_x = $signed({2'b00, cur_x_r}) + dx_s;
    sum_y = $signed({2'b00, cur_y_r}) - dy_s;

    case (phase_r)
      ps2mt_pkg::PH_DX: begin
        dx_nxt    = in_tdata;
        phase_nxt = ps2mt_pkg::PH_DY;
      end
      ps2mt_pkg::PH_DY: begin
        phase_nxt = ps2mt_pkg::PH_HEADER;
        if (hdr_r[ps2mt_pkg::HdrOvfX] | hdr_r[ps2mt_pkg::HdrOvfY]) begin
          status_nxt = ps2mt_pkg::ST_DROP;
        end else begin
          cur_x_nxt  = ps2mt_pkg::clamp_pos(sum_x, ps2mt_pkg::clamp_limit(width_r));
          cur_y_nxt  = ps2mt_pkg::clamp_pos(sum_y, ps2mt_pkg::clamp_limit(height_r));
          btn_nxt    = hdr_r[BtnW-1:0];
          ledge_nxt  = hdr_r[ps2mt_pkg::HdrBtnLeft] & ~btn_r[ps2mt_pkg::HdrBtnLeft];
          redge_nxt  = hdr_r[ps2mt_pkg::HdrBtnRight] & ~btn_r[ps2mt_pkg::HdrBtnRight];
          status_nxt = ps2mt_pkg::ST_APPLY;
        end
      end
      default: begin
        // header phase; the unused phase code lands here too
        if (in_tdata[ps2mt_pkg::HdrSync]) begin
          hdr_nxt   = in_tdata;
          phase_nxt = ps2mt_pkg::PH_DX;
        end else begin
          phase_nxt  = ps2mt_pkg::PH_HEADER;
          status_nxt = ps2mt_pkg::ST_REJECT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ps2mt_pkg::PH_HEADER;
      hdr_r   <= '0;
      dx_r    <= '0;
      cur_x_r <= ps2mt_pkg::CurXRst;
      cur_y_r <= ps2mt_pkg::CurYRst;
      btn_r   <= '0;
      ledge_r <= 1'b0;
      redge_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      dx_r    <= dx_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      btn_r   <= btn_nxt;
      ledge_r <= ledge_nxt;
      redge_r <= redge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= status_nxt;
      out_x_r      <= cur_x_nxt;
      out_y_r      <= cur_y_nxt;
      out_btn_r    <= btn_nxt;
      out_lp_r     <= ledge_nxt;
      out_rp_r     <= redge_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_rp_r, out_lp_r, out_btn_r, out_y_r, out_x_r};

  // checks
  a_reject_keeps_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status_nxt == ps2mt_pkg::ST_REJECT) |=> phase_r == ps2mt_pkg::PH_HEADER)
    else $error("rejected header left header phase");

  a_drop_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && status_nxt == ps2mt_pkg::ST_DROP) |=>
      (cur_x_r == $past(cur_x_r) && cur_y_r == $past(cur_y_r) && btn_r == $past(btn_r)))
    else $error("dropped packet changed cursor or buttons");

  a_dx_then_dy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == ps2mt_pkg::PH_DX) |=> phase_r == ps2mt_pkg::PH_DY)
    else $error("phase did not advance after X delta");

  a_edge_needs_button: assert property (@(posedge clk) disable iff (!rst_n)
    (!ledge_r || btn_r[ps2mt_pkg::HdrBtnLeft]) && (!redge_r || btn_r[ps2mt_pkg::HdrBtnRight]))
    else $error("press flag set without button held");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the PS/2 mouse packet tracker.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 150;

  typedef struct {
    ps2mt_pkg::status_t         status;
    logic [ps2mt_pkg::PosW-1:0] x;
    logic [ps2mt_pkg::PosW-1:0] y;
    logic [ps2mt_pkg::BtnW-1:0] btn;
    logic                       left_rise;
    logic                       right_rise;
  } cursor_report_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;     // [7:0] rx_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;    // [11:0] pos_x, [23:12] pos_y, [26:24] button_bits,
                                   // [27] left_press, [28] right_press
  logic [1:0]        out_tuser;    // [1:0] status
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ps2mt_pkg::CfgAw-1:0] cfg_paddr;
  logic [ps2mt_pkg::CfgDw-1:0] cfg_pwdata;
  logic [ps2mt_pkg::CfgDw-1:0] cfg_prdata;
  logic              cfg_pready;

  // tracker state as the design should hold it
  ps2mt_pkg::phase_t           trk_phase   = ps2mt_pkg::PH_HEADER;
  logic [7:0]                  trk_header  = '0;
  logic [7:0]                  trk_dx_byte = '0;
  logic [ps2mt_pkg::PosW-1:0]  trk_x       = ps2mt_pkg::CurXRst;
  logic [ps2mt_pkg::PosW-1:0]  trk_y       = ps2mt_pkg::CurYRst;
  logic [ps2mt_pkg::BtnW-1:0]  trk_buttons = '0;
  logic                        trk_left_rise  = 1'b0;
  logic                        trk_right_rise = 1'b0;
  logic [ps2mt_pkg::SizeW-1:0] scr_w = ps2mt_pkg::WidthRst;
  logic [ps2mt_pkg::SizeW-1:0] scr_h = ps2mt_pkg::HeightRst;

  cursor_report_t    pending_reports[$];

  int   cycle_count;
  int   mismatches;
  int   bytes_sent;
  int   reports_seen;
  int   applied_seen, dropped_seen, rejected_seen;
  bit   steady;
  bit   sink_hold;

  ps2_mouse_packet_tracker uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count <= CycleLimit) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [ps2mt_pkg::PosW-1:0] screen_clamp(
      input int v, input logic [ps2mt_pkg::SizeW-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > 4095) lim = 4095;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v[ps2mt_pkg::PosW-1:0];
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    cursor_report_t r;
    int dx, dy;
    r.status = ps2mt_pkg::ST_ABSORB;
    case (trk_phase)
      ps2mt_pkg::PH_DX: begin
        trk_dx_byte = b;
        trk_phase   = ps2mt_pkg::PH_DY;
      end
      ps2mt_pkg::PH_DY: begin
        trk_phase = ps2mt_pkg::PH_HEADER;
        if (trk_header[ps2mt_pkg::HdrOvfX] || trk_header[ps2mt_pkg::HdrOvfY]) begin
          r.status = ps2mt_pkg::ST_DROP;
        end else begin
          dx = int'(trk_dx_byte);
          dy = int'(b);
          if (trk_header[ps2mt_pkg::HdrSignX]) dx -= 256;
          if (trk_header[ps2mt_pkg::HdrSignY]) dy -= 256;
          // screen y grows downward
          trk_x = screen_clamp(int'(trk_x) + dx, scr_w);
          trk_y = screen_clamp(int'(trk_y) - dy, scr_h);
          trk_left_rise  = trk_header[ps2mt_pkg::HdrBtnLeft] &&
                           !trk_buttons[ps2mt_pkg::HdrBtnLeft];
          trk_right_rise = trk_header[ps2mt_pkg::HdrBtnRight] &&
                           !trk_buttons[ps2mt_pkg::HdrBtnRight];
          trk_buttons    = trk_header[ps2mt_pkg::BtnW-1:0];
          r.status = ps2mt_pkg::ST_APPLY;
        end
      end
      default: begin
        if (b[ps2mt_pkg::HdrSync]) begin
          trk_header = b;
          trk_phase  = ps2mt_pkg::PH_DX;
        end else begin
          trk_phase = ps2mt_pkg::PH_HEADER;
          r.status  = ps2mt_pkg::ST_REJECT;
        end
      end
    endcase
    r.x          = trk_x;
    r.y          = trk_y;
    r.btn        = trk_buttons;
    r.left_rise  = trk_left_rise;
    r.right_rise = trk_right_rise;
    pending_reports.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    cursor_report_t e;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected item, expected none actual tuser %0d tdata %h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        check_field("status", e.status, out_tuser);
        check_field("pos_x", e.x, out_tdata[11:0]);
        check_field("pos_y", e.y, out_tdata[23:12]);
        check_field("button_bits", e.btn, out_tdata[26:24]);
        check_field("left_press", e.left_rise, out_tdata[27]);
        check_field("right_press", e.right_rise, out_tdata[28]);
        case (e.status)
          ps2mt_pkg::ST_APPLY:  applied_seen++;
          ps2mt_pkg::ST_DROP:   dropped_seen++;
          ps2mt_pkg::ST_REJECT: rejected_seen++;
          default: ;
        endcase
      end
    end
  end

  // result side: random stalls, or a long counted hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        sink_hold = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic int idle_gap();
    int n;
    n = 0;
    if (!steady) begin
      while ($urandom_range(99) < 23 && n < 12) n++;
    end
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // lower valid and let the tracker drain before touching its registers
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input ps2mt_pkg::reg_idx_t idx,
                           input logic [ps2mt_pkg::SizeW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {19'($urandom), value};  // upper bits are don't-care
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == ps2mt_pkg::REG_WIDTH) scr_w = value;
    else scr_h = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_screen(input logic [ps2mt_pkg::SizeW-1:0] w,
                            input logic [ps2mt_pkg::SizeW-1:0] h);
    wait_idle();
    cfg_write(ps2mt_pkg::REG_WIDTH, w);
    cfg_write(ps2mt_pkg::REG_HEIGHT, h);
  endtask

  // mostly well-formed packets, some noise; big moves lean one way per call
  task automatic random_traffic(input int n);
    int sent;
    bit lean_x, lean_y;
    logic [7:0] hdr, dx, dy, junk;
    sent   = 0;
    lean_x = $urandom_range(1);
    lean_y = $urandom_range(1);
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        hdr = 8'($urandom);
        hdr[ps2mt_pkg::HdrSync] = 1'b1;
        if ($urandom_range(99) < 85) hdr[7:6] = 2'b00;
        dx = 8'($urandom);
        dy = 8'($urandom);
        if ($urandom_range(1)) begin
          hdr[ps2mt_pkg::HdrSignX] = lean_x;
          hdr[ps2mt_pkg::HdrSignY] = lean_y;
          dx = lean_x ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
          dy = lean_y ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
        end
        send_packet(hdr, dx, dy);
        sent += 3;
      end else begin
        junk = 8'($urandom);
        if ($urandom_range(99) < 70) junk[ps2mt_pkg::HdrSync] = 1'b0;
        send_byte(junk);
        sent++;
      end
    end
  endtask

  task automatic test_packet_decode();
    send_byte(8'h00);                       // header without sync bit
    send_byte(8'hF7);                       // every bit but sync
    send_packet(8'h08, 8'h00, 8'h00);       // no motion
    send_packet(8'h09, 8'h7F, 8'h7F);       // left press, largest positive deltas
    send_packet(8'h3B, 8'hFF, 8'hFF);       // both negative by one, right press
    send_packet(8'h0C, 8'h80, 8'h80);       // middle only, releases left and right
    send_packet(8'h5B, 8'h10, 8'h20);       // x overflow: dropped
    send_packet(8'hCF, 8'hFF, 8'hFF);       // both overflow: dropped
    send_packet(8'h38, 8'h00, 8'h00);       // most negative deltas
    send_packet(8'h0F, 8'hFF, 8'h01);       // all buttons from none held
  endtask

  task automatic test_screen_sizes();
    set_screen(13'd1, 13'd1);
    random_traffic(150);
    set_screen(13'd0, 13'd0);               // zero behaves like one
    random_traffic(150);
    set_screen(13'd4096, 13'd4096);
    random_traffic(150);
    set_screen(13'h1FFF, 13'h1FFF);         // past the 12-bit position range
    random_traffic(150);
    set_screen(13'd4095, 13'd2);
    random_traffic(150);
    set_screen(13'd2, 13'd4095);
    random_traffic(150);
    set_screen(ps2mt_pkg::WidthRst, ps2mt_pkg::HeightRst);
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    random_traffic(150);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    random_traffic(60);
  endtask

  task automatic test_random_screens();
    repeat (3) begin
      set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      random_traffic(60);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady      = 1'b0;
    sink_hold   = 1'b0;
    cycle_count = 0;
    mismatches  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_packet_decode();
    test_screen_sizes();
    test_steady_stream();
    test_backpressure();
    test_random_screens();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes, checked %0d result items over %0d cycles", bytes_sent,
             reports_seen, cycle_count);
    $display("Packets applied %0d, overflow drops %0d, rejected headers %0d",
             applied_seen, dropped_seen, rejected_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
